// ===== sv/cgb_pkg.sv =====
// Shared types and constants for the cursor gap buffer.
`default_nettype none

package cgb_pkg;

    localparam int BUF_DEPTH = 1024;
    localparam int WINDOW    = 10;
    localparam int MAX_STEP  = 63;

    localparam int AW  = $clog2(BUF_DEPTH);
    localparam int LW  = $clog2(BUF_DEPTH + 1);
    localparam int WCW = $clog2(WINDOW + 1);
    localparam int CW  = 8;
    localparam int SW  = 6;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_LEFT   = 2'd2,
        ACT_RIGHT  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_DELETED  = 2'd0,
        KIND_CHAR     = 2'd1,
        KIND_EMPTY    = 2'd2,
        KIND_OVERFLOW = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT_ONE,
        ST_MOVE,
        ST_WIN_START,
        ST_WIN_RD,
        ST_WIN_OUT,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic ins_write;
        logic one_load;
        logic mv_init;
        logic mv_step;
        logic win_init;
        logic win_rd;
        logic win_load;
        logic empty_load;
    } cmd_t;

    typedef struct packed {
        action_t act;
        logic    full;
        logic    mv_zero;
        logic    mv_last;
        logic    left_zero;
        logic    win_last;
        logic    out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/cgb_ctrl.sv =====
// Sequencing state machine for the cursor gap buffer.
`default_nettype none

module cgb_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire cgb_pkg::status_t sts,
    output cgb_pkg::cmd_t       cmd,
    output logic                in_stall
);

    cgb_pkg::state_t state_reg;
    cgb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cgb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cgb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cgb_pkg::ST_EXEC;
                end
            end
            cgb_pkg::ST_EXEC:
            begin
                case (sts.act)
                    cgb_pkg::ACT_INSERT:
                    begin
                        state_next = sts.full ? cgb_pkg::ST_OUT_ONE : cgb_pkg::ST_IDLE;
                    end
                    cgb_pkg::ACT_DELETE:
                    begin
                        state_next = cgb_pkg::ST_OUT_ONE;
                    end
                    default:
                    begin
                        state_next = sts.mv_zero ? cgb_pkg::ST_WIN_START : cgb_pkg::ST_MOVE;
                    end
                endcase
            end
            cgb_pkg::ST_OUT_ONE:
            begin
                if (sts.out_free)
                begin
                    state_next = cgb_pkg::ST_IDLE;
                end
            end
            cgb_pkg::ST_MOVE:
            begin
                if (sts.mv_last)
                begin
                    state_next = cgb_pkg::ST_WIN_START;
                end
            end
            cgb_pkg::ST_WIN_START:
            begin
                state_next = sts.left_zero ? cgb_pkg::ST_EMPTY : cgb_pkg::ST_WIN_RD;
            end
            cgb_pkg::ST_WIN_RD:
            begin
                state_next = cgb_pkg::ST_WIN_OUT;
            end
            cgb_pkg::ST_WIN_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.win_last ? cgb_pkg::ST_IDLE : cgb_pkg::ST_WIN_RD;
                end
            end
            cgb_pkg::ST_EMPTY:
            begin
                if (sts.out_free)
                begin
                    state_next = cgb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cgb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            cgb_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.latch_in = in_valid;
            end
            cgb_pkg::ST_EXEC:
            begin
                cmd.ins_write = (sts.act == cgb_pkg::ACT_INSERT) && !sts.full;
                cmd.mv_init   = (sts.act == cgb_pkg::ACT_LEFT) ||
                                (sts.act == cgb_pkg::ACT_RIGHT);
            end
            cgb_pkg::ST_OUT_ONE:
            begin
                cmd.one_load = sts.out_free;
            end
            cgb_pkg::ST_MOVE:
            begin
                cmd.mv_step = 1'b1;
            end
            cgb_pkg::ST_WIN_START:
            begin
                cmd.win_init = 1'b1;
            end
            cgb_pkg::ST_WIN_RD:
            begin
                cmd.win_rd = 1'b1;
            end
            cgb_pkg::ST_WIN_OUT:
            begin
                cmd.win_load = sts.out_free;
            end
            cgb_pkg::ST_EMPTY:
            begin
                cmd.empty_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/cgb_datapath.sv =====
// Text store, cursor lengths, counters and output register of the gap buffer.
`default_nettype none

module cgb_datapath
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cgb_pkg::cmd_t             cmd,
    output cgb_pkg::status_t               sts,
    input  wire logic [1:0]                action,
    input  wire logic [cgb_pkg::CW-1:0]    char_in,
    input  wire logic [cgb_pkg::SW-1:0]    step_count,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [1:0]                     kind,
    output logic [cgb_pkg::SW-1:0]         removed,
    output logic [cgb_pkg::CW-1:0]         char_out,
    output logic                           last
);

    localparam int AW  = cgb_pkg::AW;
    localparam int LW  = cgb_pkg::LW;
    localparam int WCW = cgb_pkg::WCW;
    localparam int CW  = cgb_pkg::CW;
    localparam int SW  = cgb_pkg::SW;

    logic [CW-1:0] mem [cgb_pkg::BUF_DEPTH];

    cgb_pkg::action_t act_reg;
    logic [CW-1:0]    ch_reg;
    logic [SW-1:0]    step_reg;
    logic [LW-1:0]    left_reg, left_next;
    logic [LW-1:0]    right_reg, right_next;
    logic [SW-1:0]    mv_cnt_reg, mv_cnt_next;
    logic [AW-1:0]    win_ptr_reg, win_ptr_next;
    logic [WCW-1:0]   win_cnt_reg, win_cnt_next;
    logic [CW-1:0]    rd_data_reg;
    logic             wr_pend_reg, wr_pend_next;
    logic [AW-1:0]    wr_addr_reg, wr_addr_next;

    logic             out_valid_reg, out_valid_next;
    cgb_pkg::kind_t   kind_reg, kind_next;
    logic [SW-1:0]    removed_reg, removed_next;
    logic [CW-1:0]    char_reg, char_next;
    logic             last_reg, last_next;

    logic [SW-1:0]    step_c;
    logic [LW-1:0]    side_len;
    logic [SW-1:0]    mv_n;
    logic [SW-1:0]    del_n;
    logic [LW-1:0]    win_w;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [CW-1:0]    mem_wdata;
    logic             out_free;
    logic             any_load;

    // step saturation
    always_comb
    begin
        if (32'(step_reg) > cgb_pkg::MAX_STEP)
        begin
            step_c = SW'(cgb_pkg::MAX_STEP);
        end
        else
        begin
            step_c = step_reg;
        end
    end

    assign side_len = (act_reg == cgb_pkg::ACT_LEFT) ? left_reg : right_reg;
    assign mv_n     = (LW'(step_c) < side_len) ? step_c : side_len[SW-1:0];
    assign del_n    = (LW'(step_c) < left_reg) ? step_c : left_reg[SW-1:0];
    assign win_w    = (left_reg < LW'(cgb_pkg::WINDOW)) ? left_reg : LW'(cgb_pkg::WINDOW);

    assign out_free = !out_valid_reg || !out_stall;
    assign any_load = cmd.one_load || cmd.win_load || cmd.empty_load;

    always_comb
    begin
        sts.act       = act_reg;
        sts.full      = ({1'b0, left_reg} + {1'b0, right_reg}) >=
                        (LW+1)'(cgb_pkg::BUF_DEPTH);
        sts.mv_zero   = (mv_n == '0);
        sts.mv_last   = (mv_cnt_reg == SW'(1));
        sts.left_zero = (left_reg == '0);
        sts.win_last  = (win_cnt_reg == WCW'(1));
        sts.out_free  = out_free;
    end

    // read port: move source or window character
    always_comb
    begin
        rd_en = cmd.mv_step || cmd.win_rd;
        if (cmd.win_rd)
        begin
            rd_addr = win_ptr_reg;
        end
        else if (act_reg == cgb_pkg::ACT_LEFT)
        begin
            rd_addr = AW'(left_reg - LW'(1));
        end
        else
        begin
            rd_addr = AW'(LW'(cgb_pkg::BUF_DEPTH) - right_reg);
        end
    end

    // write port: retiring move beat or an insert, never both
    always_comb
    begin
        mem_we = wr_pend_reg || cmd.ins_write;
        if (wr_pend_reg)
        begin
            mem_waddr = wr_addr_reg;
            mem_wdata = rd_data_reg;
        end
        else
        begin
            mem_waddr = left_reg[AW-1:0];
            mem_wdata = ch_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        left_next    = left_reg;
        right_next   = right_reg;
        mv_cnt_next  = mv_cnt_reg;
        win_ptr_next = win_ptr_reg;
        win_cnt_next = win_cnt_reg;
        wr_pend_next = 1'b0;
        wr_addr_next = wr_addr_reg;

        if (cmd.ins_write)
        begin
            left_next = left_reg + LW'(1);
        end
        if (cmd.one_load && (act_reg == cgb_pkg::ACT_DELETE))
        begin
            left_next = left_reg - LW'(del_n);
        end
        if (cmd.mv_init)
        begin
            mv_cnt_next = mv_n;
        end
        if (cmd.mv_step)
        begin
            mv_cnt_next  = mv_cnt_reg - SW'(1);
            wr_pend_next = 1'b1;
            if (act_reg == cgb_pkg::ACT_LEFT)
            begin
                left_next    = left_reg - LW'(1);
                right_next   = right_reg + LW'(1);
                wr_addr_next = AW'(LW'(cgb_pkg::BUF_DEPTH) - right_reg - LW'(1));
            end
            else
            begin
                left_next    = left_reg + LW'(1);
                right_next   = right_reg - LW'(1);
                wr_addr_next = left_reg[AW-1:0];
            end
        end
        if (cmd.win_init)
        begin
            win_cnt_next = WCW'(win_w);
            win_ptr_next = AW'(left_reg - win_w);
        end
        if (cmd.win_load)
        begin
            win_cnt_next = win_cnt_reg - WCW'(1);
            win_ptr_next = win_ptr_reg + AW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        removed_next   = removed_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (any_load)
        begin
            out_valid_next = 1'b1;
            removed_next   = '0;
            char_next      = '0;
            last_next      = 1'b1;
            if (cmd.win_load)
            begin
                kind_next = cgb_pkg::KIND_CHAR;
                char_next = rd_data_reg;
                last_next = sts.win_last;
            end
            else if (cmd.empty_load)
            begin
                kind_next = cgb_pkg::KIND_EMPTY;
            end
            else if (act_reg == cgb_pkg::ACT_DELETE)
            begin
                kind_next    = cgb_pkg::KIND_DELETED;
                removed_next = del_n;
            end
            else
            begin
                kind_next = cgb_pkg::KIND_OVERFLOW;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            right_reg     <= '0;
            mv_cnt_reg    <= '0;
            win_cnt_reg   <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            right_reg     <= right_next;
            mv_cnt_reg    <= mv_cnt_next;
            win_cnt_reg   <= win_cnt_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            act_reg  <= cgb_pkg::action_t'(action);
            ch_reg   <= char_in;
            step_reg <= step_count;
        end
        win_ptr_reg <= win_ptr_next;
        wr_addr_reg <= wr_addr_next;
        kind_reg    <= kind_next;
        removed_reg <= removed_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign removed   = removed_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, left_reg} + {1'b0, right_reg}) <= (LW+1)'(cgb_pkg::BUF_DEPTH))
        else $error("text length beyond store depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        any_load |-> out_free)
        else $error("result loaded over an unaccepted beat");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> !cmd.ins_write)
        else $error("move write and insert collide");

    a_move_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mv_step |-> (mv_cnt_reg != '0))
        else $error("move beat with nothing left to move");

    a_window_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.win_load |-> (win_cnt_reg != '0))
        else $error("window beat past the window end");

endmodule

`default_nettype wire

// ===== sv/cursor_gap_buffer.sv =====
// Insert: written to the store in the execute state; when full, an overflow result instead.
// Delete: result loaded once the output is free. Move of n places: one setup state, then n
// copy states (one store read and one write per place), then a window read and load per
// character while the output is free. One item at a time, taken only in the idle state.
// Reset clears the lengths, controller and output valid; store contents stay
// undefined and need no clearing pass.
`default_nettype none

module cursor_gap_buffer
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                action,
    input  wire logic [cgb_pkg::CW-1:0]    char_in,
    input  wire logic [cgb_pkg::SW-1:0]    step_count,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [1:0]                     kind,
    output logic [cgb_pkg::SW-1:0]         removed,
    output logic [cgb_pkg::CW-1:0]         char_out,
    output logic                           last
);

    cgb_pkg::cmd_t    cmd;
    cgb_pkg::status_t sts;

    cgb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    cgb_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .action     (action),
        .char_in    (char_in),
        .step_count (step_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .removed    (removed),
        .char_out   (char_out),
        .last       (last)
    );

endmodule

`default_nettype wire
